### rtl/fqlvs_pkg.sv
// ---------------------------------------------------------------------------
// fqlvs_pkg
// Shared types and constants for the quarter-line vertical field shifter.
// ---------------------------------------------------------------------------
package fqlvs_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 4096;

    localparam int PIX_W  = 8;
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int FW_W   = 12;
    localparam int FH_W   = 13;
    localparam int CFG_AW = 2;
    localparam int CFG_DW = 13;

    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 32;

    localparam int NUM_BANKS   = 3;
    localparam int BANK_W      = 2;
    localparam int MAX_RESULTS = 3;

    localparam int FIFO_DEPTH  = 8;
    localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW     = $clog2(FIFO_DEPTH + 1);
    localparam int READY_LEVEL = FIFO_DEPTH - 2 * MAX_RESULTS;

    localparam logic [FW_W-1:0] WIDTH_RESET  = FW_W'(720);
    localparam logic [FH_W-1:0] HEIGHT_RESET = FH_W'(288);
    localparam logic [FH_W-1:0] HEIGHT_MIN   = FH_W'(4);

    typedef enum logic [CFG_AW-1:0] {
        REG_FIELD_WIDTH  = 2'd0,
        REG_FIELD_HEIGHT = 2'd1,
        REG_FILTER_MODE  = 2'd2,
        REG_SHIFT_UP     = 2'd3
    } reg_index_t;

    typedef enum logic {
        MODE_LINEAR  = 1'b0,
        MODE_FOURTAP = 1'b1
    } filter_mode_t;

    // control for the item held between the line-store read and the filter
    typedef struct packed {
        filter_mode_t     mode;
        logic             up;
        logic             is_r0;
        logic             is_r1;
        logic             ge_r1;
        logic             ge_r3;
        logic             is_last;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } tap_ctl_t;

    typedef struct packed {
        logic             last;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic [PIX_W-1:0] pixel;
    } entry_t;

    typedef struct packed {
        logic [MAX_RESULTS-1:0]            valid;
        entry_t [MAX_RESULTS-1:0]          slot;
    } group_t;

endpackage

### rtl/fqlvs_ram.sv
// ---------------------------------------------------------------------------
// fqlvs_ram
// Generic single-write, single-read RAM with registered read (read-first).
// ---------------------------------------------------------------------------
module fqlvs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/fqlvs_filter.sv
// ---------------------------------------------------------------------------
// fqlvs_filter
// Vertical quarter-line filter: turns one sample and its three upper taps
// into the group of up to three output words it completes.
// ---------------------------------------------------------------------------
module fqlvs_filter (
    input  fqlvs_pkg::tap_ctl_t           ctl,
    input  logic [fqlvs_pkg::PIX_W-1:0]   cur,
    input  logic [fqlvs_pkg::PIX_W-1:0]   p1,
    input  logic [fqlvs_pkg::PIX_W-1:0]   p2,
    input  logic [fqlvs_pkg::PIX_W-1:0]   p3,
    output fqlvs_pkg::group_t             grp
);

    import fqlvs_pkg::*;

    function automatic logic [PIX_W-1:0] four_tap(
        input logic [PIX_W-1:0] a,
        input logic [PIX_W-1:0] b,
        input logic [PIX_W-1:0] c,
        input logic [PIX_W-1:0] d
    );
        logic signed [17:0] sa;
        logic signed [17:0] sb;
        logic signed [17:0] sc;
        logic signed [17:0] sd;
        logic signed [17:0] biased;
        logic signed [17:0] shifted;
        logic [PIX_W-1:0]   res;
        sa      = $signed({10'd0, a});
        sb      = $signed({10'd0, b});
        sc      = $signed({10'd0, c});
        sd      = $signed({10'd0, d});
        biased  = 18'sd111 * sb + 18'sd29 * sc - 18'sd9 * sa - 18'sd3 * sd + 18'sd64;
        shifted = biased >>> 7;
        if (biased < 18'sd0)
        begin
            res = '0;
        end
        else if (shifted > 18'sd255)
        begin
            res = 8'd255;
        end
        else
        begin
            res = shifted[PIX_W-1:0];
        end
        return res;
    endfunction

    logic [9:0]       sum_dn;
    logic [9:0]       sum_up;
    logic [PIX_W-1:0] rnd_dn;
    logic [PIX_W-1:0] rnd_up;
    logic [PIX_W-1:0] lin_dn;
    logic [PIX_W-1:0] lin_up;
    logic [PIX_W-1:0] ft_out;
    logic [PIX_W-1:0] ft_a;
    logic [PIX_W-1:0] ft_b;
    logic [PIX_W-1:0] ft_c;
    logic [PIX_W-1:0] ft_d;
    logic [9:0]       rnd_dn_sum;
    logic [9:0]       rnd_up_sum;

    // 3 parts of the nearer line, 1 part of the farther one
    assign sum_dn     = {2'b00, cur} + 10'(3) * {2'b00, p1};
    assign sum_up     = {2'b00, p1} + 10'(3) * {2'b00, cur};
    assign rnd_dn_sum = sum_dn + 10'd2;
    assign rnd_up_sum = sum_up + 10'd2;
    assign rnd_dn     = rnd_dn_sum[9:2];
    assign rnd_up     = rnd_up_sum[9:2];
    assign lin_dn     = sum_dn[9:2];
    assign lin_up     = sum_up[9:2];

    // mirrored tap order when shifting up
    assign ft_a   = ctl.up ? cur : p3;
    assign ft_b   = ctl.up ? p1  : p2;
    assign ft_c   = ctl.up ? p2  : p1;
    assign ft_d   = ctl.up ? p3  : cur;
    assign ft_out = four_tap(ft_a, ft_b, ft_c, ft_d);

    always_comb
    begin
        grp = '0;
        for (int k = 0; k < MAX_RESULTS; k++)
        begin
            grp.slot[k].col = ctl.col;
        end

        case (ctl.mode)
            MODE_FOURTAP:
            begin
                if (!ctl.up)
                begin
                    grp.valid[0] = ctl.is_r1 | ctl.ge_r3;
                    if (ctl.is_r1)
                    begin
                        grp.slot[0].pixel = rnd_dn;
                        grp.slot[0].row   = '0;
                    end
                    else
                    begin
                        grp.slot[0].pixel = ft_out;
                        grp.slot[0].row   = ctl.row - ROW_W'(2);
                    end
                    grp.valid[1]      = ctl.is_last;
                    grp.slot[1].pixel = rnd_dn;
                    grp.slot[1].row   = ctl.row - ROW_W'(1);
                    grp.valid[2]      = ctl.is_last;
                    grp.slot[2].pixel = cur;
                    grp.slot[2].row   = ctl.row;
                end
                else
                begin
                    grp.valid[0] = ctl.is_r0 | ctl.is_r1 | ctl.ge_r3;
                    if (ctl.is_r0)
                    begin
                        grp.slot[0].pixel = cur;
                        grp.slot[0].row   = '0;
                    end
                    else if (ctl.is_r1)
                    begin
                        grp.slot[0].pixel = rnd_up;
                        grp.slot[0].row   = ROW_W'(1);
                    end
                    else
                    begin
                        grp.slot[0].pixel = ft_out;
                        grp.slot[0].row   = ctl.row - ROW_W'(1);
                    end
                    grp.valid[1]      = ctl.is_last;
                    grp.slot[1].pixel = rnd_up;
                    grp.slot[1].row   = ctl.row;
                end
            end
            MODE_LINEAR:
            begin
                if (!ctl.up)
                begin
                    grp.valid[0]      = ctl.ge_r1;
                    grp.slot[0].pixel = lin_dn;
                    grp.slot[0].row   = ctl.row - ROW_W'(1);
                    grp.valid[1]      = ctl.is_last;
                    grp.slot[1].pixel = cur;
                    grp.slot[1].row   = ctl.row;
                end
                else
                begin
                    grp.valid[0]      = 1'b1;
                    grp.slot[0].pixel = ctl.is_r0 ? cur : lin_up;
                    grp.slot[0].row   = ctl.row;
                end
            end
            default:
            begin
                grp.valid = '0;
            end
        endcase

        // valid slots are contiguous from slot 0, so mark the highest one
        if (grp.valid[2])
        begin
            grp.slot[2].last = 1'b1;
        end
        else if (grp.valid[1])
        begin
            grp.slot[1].last = 1'b1;
        end
        else
        begin
            grp.slot[0].last = grp.valid[0];
        end
    end

endmodule

### rtl/field_quarter_line_vertical_shift.sv
// ---------------------------------------------------------------------------
// field_quarter_line_vertical_shift
// Shifts an 8-bit video field a quarter line up or down with a linear or
// four-tap vertical filter, using three line banks and row/column counters.
//
//  channel   dir  fields (lsb first)                       handshake
//  s_axis    in   tdata: pixel_in                          tvalid/tready
//  m_axis    out  tdata: pixel_out, out_row, out_col       tvalid/tready
//                 tlast: last_of_run
//  cfg       in   addr 0 width, 1 height, 2 mode, 3 up     cfg_we
//
// One pixel is taken per cycle while s_axis_tready is high; its words pass the
// line-bank read and tap register, then the filter, into the output queue.
// Up to three words per pixel go into an 8-word output queue that drains one
// word per cycle while m_axis_tready is high; s_axis_tready drops while the
// queue holds more than two words, so the input is held back on the last line,
// where four-tap down mode gives three words per pixel and four-tap up and linear down mode two.
// Output stalls only fill the queue.
// Reset clears counters, queue and config; the line banks need no clearing.
// ---------------------------------------------------------------------------
module field_quarter_line_vertical_shift (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [fqlvs_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // [7:0] pixel_in
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // [7:0] pixel_out, [19:8] out_row, [30:20] out_col, [31] zero
    output logic [fqlvs_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    output logic                                 m_axis_tlast,
    input  logic                                 cfg_we,
    input  logic [fqlvs_pkg::CFG_AW-1:0]         cfg_addr,
    input  logic [fqlvs_pkg::CFG_DW-1:0]         cfg_wdata
);

    import fqlvs_pkg::*;

    // configuration
    logic [FW_W-1:0]  field_width_reg;
    logic [FH_W-1:0]  field_height_reg;
    filter_mode_t     filter_mode_reg;
    logic             shift_up_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            field_width_reg  <= WIDTH_RESET;
            field_height_reg <= HEIGHT_RESET;
            filter_mode_reg  <= MODE_FOURTAP;
            shift_up_reg     <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (reg_index_t'(cfg_addr))
                REG_FIELD_WIDTH:  field_width_reg  <= cfg_wdata[FW_W-1:0];
                REG_FIELD_HEIGHT: field_height_reg <= cfg_wdata[FH_W-1:0];
                REG_FILTER_MODE:  filter_mode_reg  <= filter_mode_t'(cfg_wdata[0]);
                REG_SHIFT_UP:     shift_up_reg     <= cfg_wdata[0];
                default:          shift_up_reg     <= shift_up_reg;
            endcase
        end
    end

    // effective geometry and position of the incoming pixel
    logic [FW_W-1:0]   w_eff;
    logic [FH_W-1:0]   h_eff;
    logic [COL_W-1:0]  col_count_reg;
    logic [COL_W-1:0]  col_count_next;
    logic [ROW_W-1:0]  row_count_reg;
    logic [ROW_W-1:0]  row_count_next;
    logic [BANK_W-1:0] row_bank_reg;
    logic [BANK_W-1:0] row_bank_next;
    logic [COL_W-1:0]  cur_col;
    logic [ROW_W-1:0]  cur_row;
    logic [BANK_W-1:0] cur_bank;
    logic [FW_W-1:0]   col_inc;
    logic [FH_W-1:0]   row_inc;
    logic              accept;

    always_comb
    begin
        if (field_width_reg == '0)
        begin
            w_eff = FW_W'(1);
        end
        else if (field_width_reg > FW_W'(MAX_WIDTH))
        begin
            w_eff = FW_W'(MAX_WIDTH);
        end
        else
        begin
            w_eff = field_width_reg;
        end

        if (field_height_reg < HEIGHT_MIN)
        begin
            h_eff = HEIGHT_MIN;
        end
        else if (field_height_reg > FH_W'(MAX_HEIGHT))
        begin
            h_eff = FH_W'(MAX_HEIGHT);
        end
        else
        begin
            h_eff = field_height_reg;
        end
    end

    // counters left past a shrunken bound restart at zero
    always_comb
    begin
        if (FW_W'(col_count_reg) >= w_eff)
        begin
            cur_col = '0;
        end
        else
        begin
            cur_col = col_count_reg;
        end

        if (FH_W'(row_count_reg) >= h_eff)
        begin
            cur_row  = '0;
            cur_bank = '0;
        end
        else
        begin
            cur_row  = row_count_reg;
            cur_bank = row_bank_reg;
        end

        col_inc = FW_W'(cur_col) + FW_W'(1);
        row_inc = FH_W'(cur_row) + FH_W'(1);

        col_count_next = col_count_reg;
        row_count_next = row_count_reg;
        row_bank_next  = row_bank_reg;
        if (accept)
        begin
            col_count_next = col_inc[COL_W-1:0];
            row_count_next = cur_row;
            row_bank_next  = cur_bank;
            if (col_inc >= w_eff)
            begin
                col_count_next = '0;
                if (row_inc >= h_eff)
                begin
                    row_count_next = '0;
                    row_bank_next  = '0;
                end
                else
                begin
                    row_count_next = row_inc[ROW_W-1:0];
                    row_bank_next  = (cur_bank == BANK_W'(NUM_BANKS - 1)) ?
                                     '0 : cur_bank + BANK_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg <= '0;
            row_count_reg <= '0;
            row_bank_reg  <= '0;
        end
        else
        begin
            col_count_reg <= col_count_next;
            row_count_reg <= row_count_next;
            row_bank_reg  <= row_bank_next;
        end
    end

    // line banks: one per row modulo 3, read-first so the bank being
    // overwritten still returns the line three rows up
    logic [PIX_W-1:0] bank_rdata [NUM_BANKS];

    for (genvar g = 0; g < NUM_BANKS; g++)
    begin : g_bank
        fqlvs_ram #(
            .WIDTH (PIX_W),
            .DEPTH (MAX_WIDTH)
        ) u_ram (
            .clk   (clk),
            .we    (accept && (cur_bank == BANK_W'(g))),
            .waddr (cur_col),
            .wdata (s_axis_tdata[PIX_W-1:0]),
            .re    (accept),
            .raddr (cur_col),
            .rdata (bank_rdata[g])
        );
    end

    // tap stage
    logic              s1_valid_reg;
    tap_ctl_t          s1_ctl_reg;
    tap_ctl_t          s1_ctl_next;
    logic [PIX_W-1:0]  s1_cur_reg;
    logic [BANK_W-1:0] s1_bank_reg;

    always_comb
    begin
        s1_ctl_next.mode    = filter_mode_reg;
        s1_ctl_next.up      = shift_up_reg;
        s1_ctl_next.is_r0   = (cur_row == '0);
        s1_ctl_next.is_r1   = (cur_row == ROW_W'(1));
        s1_ctl_next.ge_r1   = (cur_row >= ROW_W'(1));
        s1_ctl_next.ge_r3   = (cur_row >= ROW_W'(3));
        s1_ctl_next.is_last = (FH_W'(cur_row) == h_eff - FH_W'(1));
        s1_ctl_next.row     = cur_row;
        s1_ctl_next.col     = cur_col;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_ctl_reg  <= s1_ctl_next;
            s1_cur_reg  <= s_axis_tdata[PIX_W-1:0];
            s1_bank_reg <= cur_bank;
        end
    end

    // p1 sits one bank back, p2 two back, p3 in the bank just written
    logic [PIX_W-1:0] tap_p1;
    logic [PIX_W-1:0] tap_p2;
    logic [PIX_W-1:0] tap_p3;

    always_comb
    begin
        case (s1_bank_reg)
            2'd0:
            begin
                tap_p1 = bank_rdata[2];
                tap_p2 = bank_rdata[1];
                tap_p3 = bank_rdata[0];
            end
            2'd1:
            begin
                tap_p1 = bank_rdata[0];
                tap_p2 = bank_rdata[2];
                tap_p3 = bank_rdata[1];
            end
            default:
            begin
                tap_p1 = bank_rdata[1];
                tap_p2 = bank_rdata[0];
                tap_p3 = bank_rdata[2];
            end
        endcase
    end

    group_t grp;

    fqlvs_filter u_filter (
        .ctl (s1_ctl_reg),
        .cur (s1_cur_reg),
        .p1  (tap_p1),
        .p2  (tap_p2),
        .p3  (tap_p3),
        .grp (grp)
    );

    // output queue
    entry_t             fifo_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg;
    logic [FIFO_AW-1:0] wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg;
    logic [FIFO_AW-1:0] rd_ptr_next;
    logic [FIFO_CW-1:0] count_reg;
    logic [FIFO_CW-1:0] count_next;
    logic [1:0]         push_n;
    logic               pop;
    entry_t             head;

    assign push_n = s1_valid_reg ?
                    (2'(grp.valid[0]) + 2'(grp.valid[1]) + 2'(grp.valid[2])) : 2'd0;
    assign pop         = m_axis_tvalid && m_axis_tready;
    assign wr_ptr_next = wr_ptr_reg + FIFO_AW'(push_n);
    assign rd_ptr_next = rd_ptr_reg + FIFO_AW'(pop);
    assign count_next  = count_reg + FIFO_CW'(push_n) - FIFO_CW'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < MAX_RESULTS; k++)
        begin
            if (s1_valid_reg && grp.valid[k])
            begin
                fifo_reg[wr_ptr_reg + FIFO_AW'(k)] <= grp.slot[k];
            end
        end
    end

    // room for the word group in the tap stage plus the one accepted now
    assign s_axis_tready = (count_reg <= FIFO_CW'(READY_LEVEL));
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign head          = fifo_reg[rd_ptr_reg];
    assign m_axis_tvalid = (count_reg != '0);
    assign m_axis_tdata  = {1'b0, head.col, head.row, head.pixel};
    assign m_axis_tlast  = head.last;

endmodule
